// ----- hw/rtl/lcv_pkg.sv -----
// Shared widths, region codes, register indexes and handshake structs of the line clipper.
package lcv_pkg;

    localparam int COORD_BITS = 16;
    localparam int CW         = COORD_BITS;
    localparam int DW         = CW + 1;
    localparam int PW         = 2 * DW;
    localparam int DIV_CNT_W  = $clog2(DW + 1);

    localparam int NUM_REGS       = 8;
    localparam int REG_IDX_W      = $clog2(NUM_REGS);
    localparam int CFG_IDX_W      = 8;
    localparam int MAX_CLIP_STEPS = 16;
    localparam int STEP_W         = $clog2(MAX_CLIP_STEPS + 1);

    localparam logic [3:0] CODE_RIGHT  = 4'b1000;
    localparam logic [3:0] CODE_TOP    = 4'b0100;
    localparam logic [3:0] CODE_LEFT   = 4'b0010;
    localparam logic [3:0] CODE_BOTTOM = 4'b0001;

    localparam logic [REG_IDX_W-1:0] REG_WMIN_X = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_WMIN_Y = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_WMAX_X = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_WMAX_Y = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_VMIN_X = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_VMIN_Y = REG_IDX_W'(5);
    localparam logic [REG_IDX_W-1:0] REG_VMAX_X = REG_IDX_W'(6);
    localparam logic [REG_IDX_W-1:0] REG_VMAX_Y = REG_IDX_W'(7);

    localparam logic signed [CW-1:0] CFG_RESET [NUM_REGS] = '{
        CW'(50), CW'(50), CW'(100), CW'(100), CW'(150), CW'(150), CW'(400), CW'(400)
    };

    typedef struct packed {
        logic                 start;
        logic signed [DW-1:0] a;
        logic signed [DW-1:0] b;
        logic signed [DW-1:0] c;
    } t_md_req;

    typedef struct packed {
        logic                 done;
        logic signed [DW-1:0] q;
    } t_md_rsp;

    function automatic logic signed [DW-1:0] sx(input logic signed [CW-1:0] v);
        sx = {v[CW-1], v};
    endfunction

endpackage

// ----- hw/rtl/lcv_muldiv.sv -----
// Shared unit that forms a * b / c with one multiply and a bit-serial restoring divide.
module lcv_muldiv
    import lcv_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_md_req i_req,
    output t_md_rsp o_rsp
);

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_ABS  = 2'd1;
    localparam logic [1:0] M_DIV  = 2'd2;

    logic [1:0]           r_state;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic signed [PW-1:0] r_prod;
    logic                 r_neg;
    logic                 r_zero;
    logic [DW-1:0]        r_div;
    logic [DW-1:0]        r_rem;
    logic [DW-1:0]        r_quo;

    logic signed [PW-1:0] prod;
    logic [PW-1:0]        prod_mag;
    logic [DW:0]          rem_sh;
    logic [DW+1:0]        diff;
    logic signed [DW-1:0] c_mag;

    always_comb begin
        prod     = PW'(i_req.a) * PW'(i_req.b);
        c_mag    = i_req.c[DW-1] ? -i_req.c : i_req.c;
        prod_mag = r_prod[PW-1] ? PW'(-r_prod) : PW'(r_prod);
        rem_sh   = {r_rem, r_quo[DW-1]};
        diff     = {1'b0, rem_sh} - {2'b00, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= (r_state == M_DIV) && (r_cnt == DIV_CNT_W'(1));
            unique case (r_state)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_prod  <= prod;
                        r_neg   <= i_req.a[DW-1] ^ i_req.b[DW-1] ^ i_req.c[DW-1];
                        r_zero  <= (i_req.c == '0);
                        r_div   <= c_mag;
                        r_state <= M_ABS;
                    end
                end
                M_ABS: begin
                    r_rem   <= prod_mag[PW-1:DW];
                    r_quo   <= prod_mag[DW-1:0];
                    r_cnt   <= DIV_CNT_W'(DW);
                    r_state <= M_DIV;
                end
                M_DIV: begin
                    if (!diff[DW+1]) begin
                        r_rem <= diff[DW-1:0];
                    end else begin
                        r_rem <= rem_sh[DW-1:0];
                    end
                    r_quo <= {r_quo[DW-2:0], ~diff[DW+1]};
                    r_cnt <= r_cnt - DIV_CNT_W'(1);
                    if (r_cnt == DIV_CNT_W'(1)) begin
                        r_state <= M_IDLE;
                    end
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        if (r_zero) begin
            o_rsp.q = '0;
        end else if (r_neg) begin
            o_rsp.q = -$signed(r_quo);
        end else begin
            o_rsp.q = $signed(r_quo);
        end
    end

endmodule

// ----- hw/rtl/line_clip_to_viewport_core.sv -----
// Top level of the segment clipper with window-to-viewport mapping.
//
//  channel  | direction | handshake                    | word
//  ---------+-----------+------------------------------+------------------------------------
//  s_axis   | in        | s_axis_tvalid/s_axis_tready  | segment endpoints
//  m_axis   | out       | m_axis_tvalid/m_axis_tready  | mapped endpoints, visible flag
//  cfg      | in        | i_cfg_valid/o_cfg_ready      | register index and value
//
// A segment that is rejected outright goes from S_CHECK straight to S_DONE; otherwise it runs
// up to 16 clip steps, and a visible segment then runs four viewport mappings.
// Each clip step and each of the four viewport mappings runs one multiply and a serial
// divide on the single shared unit.
// Synchronous active-low reset restores the register reset values; the output register
// lets the next segment start while a result is still held by a stalled consumer.
module line_clip_to_viewport_core
    import lcv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [4*CW-1:0]      s_axis_tdata,  // start_x, start_y, end_x, end_y
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [4*CW-1:0]      m_axis_tdata,  // out_start_x, out_start_y, out_end_x, out_end_y
    output logic                 m_axis_tuser,  // visible
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CW-1:0]        i_cfg_data
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_CHECK     = 3'd1;
    localparam logic [2:0] S_CLIP_WAIT = 3'd2;
    localparam logic [2:0] S_MAP       = 3'd3;
    localparam logic [2:0] S_MAP_WAIT  = 3'd4;
    localparam logic [2:0] S_DONE      = 3'd5;

    logic signed [CW-1:0] r_cfg [NUM_REGS];
    logic [2:0]           r_state;
    logic signed [CW-1:0] r_x0, r_y0, r_x1, r_y1;
    logic [STEP_W-1:0]    r_steps;
    logic                 r_pick1;
    logic                 r_axis_y;
    logic signed [CW-1:0] r_edge;
    logic [1:0]           r_k;
    logic                 r_vis;
    logic signed [CW-1:0] r_res [4];
    logic                 r_ovalid;
    logic                 r_ovis;
    logic [4*CW-1:0]      r_odata;

    t_md_req md_req;
    t_md_rsp md_rsp;

    logic [3:0]           c0, c1, co;
    logic                 degenerate;
    logic signed [CW-1:0] edge_val;
    logic signed [DW-1:0] base;
    logic signed [DW-1:0] nval;
    logic signed [CW-1:0] map_p;
    logic signed [CW-1:0] map_wmin, map_wmax, map_vmin, map_vmax;
    logic signed [DW-1:0] map_sum;
    logic                 out_free;

    function automatic logic [3:0] region(input logic signed [CW-1:0] x,
                                          input logic signed [CW-1:0] y,
                                          input logic signed [CW-1:0] wminx,
                                          input logic signed [CW-1:0] wminy,
                                          input logic signed [CW-1:0] wmaxx,
                                          input logic signed [CW-1:0] wmaxy);
        logic [3:0] code;
        code = '0;
        if (y > wmaxy) begin
            code = code | CODE_TOP;
        end else if (y < wminy) begin
            code = code | CODE_BOTTOM;
        end
        if (x > wmaxx) begin
            code = code | CODE_RIGHT;
        end else if (x < wminx) begin
            code = code | CODE_LEFT;
        end
        region = code;
    endfunction

    lcv_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ovis;
    assign out_free      = !r_ovalid || m_axis_tready;

    always_comb begin
        degenerate = (r_cfg[REG_WMAX_X] <= r_cfg[REG_WMIN_X]) ||
                     (r_cfg[REG_WMAX_Y] <= r_cfg[REG_WMIN_Y]);
        c0 = region(r_x0, r_y0, r_cfg[REG_WMIN_X], r_cfg[REG_WMIN_Y],
                    r_cfg[REG_WMAX_X], r_cfg[REG_WMAX_Y]);
        c1 = region(r_x1, r_y1, r_cfg[REG_WMIN_X], r_cfg[REG_WMIN_Y],
                    r_cfg[REG_WMAX_X], r_cfg[REG_WMAX_Y]);
        co = (c0 != '0) ? c0 : c1;

        map_p    = r_k[1] ? (r_k[0] ? r_y1 : r_x1) : (r_k[0] ? r_y0 : r_x0);
        map_wmin = r_k[0] ? r_cfg[REG_WMIN_Y] : r_cfg[REG_WMIN_X];
        map_wmax = r_k[0] ? r_cfg[REG_WMAX_Y] : r_cfg[REG_WMAX_X];
        map_vmin = r_k[0] ? r_cfg[REG_VMIN_Y] : r_cfg[REG_VMIN_X];
        map_vmax = r_k[0] ? r_cfg[REG_VMAX_Y] : r_cfg[REG_VMAX_X];

        md_req.start = 1'b0;
        md_req.a     = '0;
        md_req.b     = '0;
        md_req.c     = '0;
        edge_val     = r_cfg[REG_WMIN_X];
        priority if ((co & CODE_TOP) != '0) begin
            edge_val = r_cfg[REG_WMAX_Y];
        end else if ((co & CODE_BOTTOM) != '0) begin
            edge_val = r_cfg[REG_WMIN_Y];
        end else if ((co & CODE_RIGHT) != '0) begin
            edge_val = r_cfg[REG_WMAX_X];
        end else begin
            edge_val = r_cfg[REG_WMIN_X];
        end

        if (r_state == S_CHECK) begin
            if ((co & (CODE_TOP | CODE_BOTTOM)) != '0) begin
                md_req.a = sx(r_x1) - sx(r_x0);
                md_req.b = sx(edge_val) - sx(r_y0);
                md_req.c = sx(r_y1) - sx(r_y0);
            end else begin
                md_req.a = sx(r_y1) - sx(r_y0);
                md_req.b = sx(edge_val) - sx(r_x0);
                md_req.c = sx(r_x1) - sx(r_x0);
            end
            md_req.start = !degenerate && ((c0 | c1) != '0) && ((c0 & c1) == '0) &&
                           (r_steps != STEP_W'(MAX_CLIP_STEPS));
        end else if (r_state == S_MAP) begin
            md_req.a     = sx(map_p) - sx(map_wmin);
            md_req.b     = sx(map_vmax) - sx(map_vmin);
            md_req.c     = sx(map_wmax) - sx(map_wmin);
            md_req.start = 1'b1;
        end

        base    = r_axis_y ? sx(r_x0) : sx(r_y0);
        nval    = base + md_rsp.q;
        map_sum = sx(map_vmin) + md_rsp.q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(NUM_REGS))) begin
            r_cfg[i_cfg_index[REG_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_steps  <= '0;
            r_k      <= '0;
            r_vis    <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_x0    <= s_axis_tdata[CW-1:0];
                        r_y0    <= s_axis_tdata[2*CW-1:CW];
                        r_x1    <= s_axis_tdata[3*CW-1:2*CW];
                        r_y1    <= s_axis_tdata[4*CW-1:3*CW];
                        r_steps <= '0;
                        r_k     <= '0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    priority if (degenerate) begin
                        r_vis   <= 1'b0;
                        r_state <= S_DONE;
                    end else if ((c0 | c1) == '0) begin
                        r_vis   <= 1'b1;
                        r_state <= S_MAP;
                    end else if (((c0 & c1) != '0) || (r_steps == STEP_W'(MAX_CLIP_STEPS))) begin
                        r_vis   <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_pick1  <= (c0 == '0);
                        r_axis_y <= ((co & (CODE_TOP | CODE_BOTTOM)) != '0);
                        r_edge   <= edge_val;
                        r_state  <= S_CLIP_WAIT;
                    end
                end
                S_CLIP_WAIT: begin
                    if (md_rsp.done) begin
                        if (r_pick1) begin
                            r_x1 <= r_axis_y ? nval[CW-1:0] : r_edge;
                            r_y1 <= r_axis_y ? r_edge : nval[CW-1:0];
                        end else begin
                            r_x0 <= r_axis_y ? nval[CW-1:0] : r_edge;
                            r_y0 <= r_axis_y ? r_edge : nval[CW-1:0];
                        end
                        r_steps <= r_steps + STEP_W'(1);
                        r_state <= S_CHECK;
                    end
                end
                S_MAP: begin
                    r_state <= S_MAP_WAIT;
                end
                S_MAP_WAIT: begin
                    if (md_rsp.done) begin
                        r_res[r_k] <= map_sum[CW-1:0];
                        r_k        <= r_k + 2'd1;
                        r_state    <= (r_k == 2'd3) ? S_DONE : S_MAP;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_ovis   <= r_vis;
                        r_odata  <= r_vis ? {r_res[3], r_res[2], r_res[1], r_res[0]} : '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_rsp.done |-> (r_state == S_CLIP_WAIT || r_state == S_MAP_WAIT))
        else $error("divider finished outside a wait state");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("rejected segment carries nonzero coordinates");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps <= STEP_W'(MAX_CLIP_STEPS))
        else $error("clip step count ran past its limit");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_CHECK))
        else $error("accepted segment did not start clipping");
`endif

endmodule
